[hw/rtl/ibml_pkg.sv]
`timescale 1ns / 1ps

package ibml_pkg;

    localparam int DIRECT_REFS    = 4;
    localparam int INDIRECT_REFS  = 2;
    localparam int DOUBLE_REFS    = 1;
    localparam int REFS_PER_BLOCK = 256;
    localparam int INODE_COUNT    = 64;
    localparam int DATA_BLOCKS    = 256;

    localparam int SLOTS_PER_INODE   = DIRECT_REFS + INDIRECT_REFS + DOUBLE_REFS;
    localparam int INODE_STORE_DEPTH = INODE_COUNT * SLOTS_PER_INODE;
    localparam int WORD_STORE_DEPTH  = DATA_BLOCKS * REFS_PER_BLOCK;

    localparam int INODE_AW = $clog2(INODE_STORE_DEPTH);
    localparam int WORD_AW  = $clog2(WORD_STORE_DEPTH);
    localparam int SLOT_W   = $clog2(SLOTS_PER_INODE + 1);
    // Word positions are taken apart by shift and mask: a block holds a power of two words.
    localparam int RPB_W    = $clog2(REFS_PER_BLOCK);

    localparam longint IND_END   = longint'(DIRECT_REFS)
                                   + longint'(INDIRECT_REFS) * longint'(REFS_PER_BLOCK);
    localparam longint FBN_LIMIT = IND_END + longint'(DOUBLE_REFS)
                                   * longint'(REFS_PER_BLOCK) * longint'(REFS_PER_BLOCK);

    typedef enum logic [1:0] {
        CMD_LOAD_INODE = 2'd0,
        CMD_LOAD_WORD  = 2'd1,
        CMD_LOOKUP     = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_BEYOND = 2'd2
    } status_t;

    function automatic logic [INODE_AW-1:0] inode_addr(input logic [5:0] ino,
                                                       input logic [SLOT_W-1:0] slot);
        return INODE_AW'(32'(ino) * 32'(SLOTS_PER_INODE) + 32'(slot));
    endfunction

    function automatic logic [WORD_AW-1:0] word_addr(input logic [31:0] blk,
                                                     input logic [RPB_W-1:0] idx);
        return WORD_AW'(blk * 32'(REFS_PER_BLOCK) + 32'(idx));
    endfunction

endpackage

[hw/rtl/ibml_if.sv]
`timescale 1ns / 1ps

interface ibml_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [5:0]  inode;
    logic [2:0]  slot;
    logic [7:0]  data_block;
    logic [7:0]  word_index;
    logic [31:0] value;
    logic [31:0] file_block;

    modport source (output valid, cmd, inode, slot, data_block, word_index, value, file_block,
                    input ready);
    modport sink (input valid, cmd, inode, slot, data_block, word_index, value, file_block,
                  output ready);
endinterface

interface ibml_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_ref;
    logic [1:0]  status;

    modport source (output valid, block_ref, status, input ready);
    modport sink (input valid, block_ref, status, output ready);
endinterface

interface ibml_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[hw/rtl/ibml_ram.sv]
`timescale 1ns / 1ps

module ibml_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // Read data holds until the next read, so a stalled consumer can still use it.
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/inode_block_map_lookup.sv]
`timescale 1ns / 1ps

// Translates a file block of an inode into a disk block reference. Beats on req load an inode
// reference slot (cmd 0), load a word of an indirect data block (cmd 1) or look up a file
// block (cmd 2); each beat gives exactly one beat on rsp. Loads finish in the cycle they are
// taken. A lookup reads the inode store and then up to two words of the block store, each read
// registered in its RAM (a direct hit reads none, a single-indirect one and a double-indirect
// two); results wait while rsp is held off. Items are worked one at a time; a lookup is taken
// while the previous result still waits on rsp. The user must write the null reference value
// on cfg only while the block is idle; the block does not enforce this. Reset sets it to all ones.
// Neither store is cleared at reset: a lookup must only follow entries that were loaded before.
module inode_block_map_lookup
    import ibml_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ibml_req_if.sink    req,
    ibml_rsp_if.source  rsp,
    ibml_cfg_if.sink    cfg
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INODE,
        ST_MID,
        ST_FINAL
    } state_t;

    typedef enum logic [1:0] {
        KIND_ERR,
        KIND_DIRECT,
        KIND_INDIRECT,
        KIND_DOUBLE
    } kind_t;

    state_t             state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic [RPB_W-1:0]   p2_reg, p2_next;
    logic [RPB_W-1:0]   p3_reg, p3_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_ref_reg, out_ref_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic [31:0]        null_ref_reg, null_ref_next;

    logic               inode_we, inode_re;
    logic [INODE_AW-1:0] inode_waddr, inode_raddr;
    logic [31:0]        inode_rdata;
    logic               word_we, word_re;
    logic [WORD_AW-1:0] word_waddr, word_raddr;
    logic [31:0]        word_rdata;

    logic               out_free;
    logic               accept;

    assign out_free = !out_valid_reg || rsp.ready;
    assign accept   = req.valid && req.ready;

    assign req.ready = (state_reg == ST_IDLE) && (out_free || req.cmd == CMD_LOOKUP);
    assign cfg.ready = 1'b1;

    assign rsp.valid     = out_valid_reg;
    assign rsp.block_ref = out_ref_reg;
    assign rsp.status    = out_status_reg;

    ibml_ram #(.WIDTH(32), .DEPTH(INODE_STORE_DEPTH)) u_inode_ram (
        .clk     (clk),
        .wr_en   (inode_we),
        .wr_addr (inode_waddr),
        .wr_data (req.value),
        .rd_en   (inode_re),
        .rd_addr (inode_raddr),
        .rd_data (inode_rdata)
    );

    ibml_ram #(.WIDTH(32), .DEPTH(WORD_STORE_DEPTH)) u_word_ram (
        .clk     (clk),
        .wr_en   (word_we),
        .wr_addr (word_waddr),
        .wr_data (req.value),
        .rd_en   (word_re),
        .rd_addr (word_raddr),
        .rd_data (word_rdata)
    );

    always_comb
    begin
        logic [31:0]       fbn;
        logic [31:0]       ind_off;
        logic [31:0]       dbl_off;
        logic [31:0]       slot_sel;
        logic              ino_ok;
        logic              ref_null;
        logic              ref_beyond;
        logic [31:0]       cur_ref;

        fbn      = req.file_block;
        ind_off  = fbn - 32'(DIRECT_REFS);
        dbl_off  = fbn - 32'(IND_END);
        slot_sel = 32'd0;
        ino_ok   = 32'(req.inode) < 32'(INODE_COUNT);
        cur_ref  = (state_reg == ST_INODE) ? inode_rdata : word_rdata;
        ref_null   = cur_ref == null_ref_reg;
        ref_beyond = {1'b0, cur_ref} >= 33'(DATA_BLOCKS);

        state_next      = state_reg;
        kind_next       = kind_reg;
        p2_next         = p2_reg;
        p3_next         = p3_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_ref_next    = out_ref_reg;
        out_status_next = out_status_reg;
        null_ref_next   = null_ref_reg;

        inode_we    = 1'b0;
        inode_waddr = inode_addr(req.inode, SLOT_W'(req.slot));
        inode_re    = 1'b0;
        inode_raddr = '0;
        word_we     = 1'b0;
        word_waddr  = word_addr(32'(req.data_block), RPB_W'(req.word_index));
        word_re     = 1'b0;
        word_raddr  = '0;

        if (cfg.valid)
        begin
            null_ref_next = cfg.data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == CMD_LOOKUP)
                    begin
                        state_next = ST_INODE;
                        if ({1'b0, fbn} >= 33'(FBN_LIMIT) || !ino_ok)
                        begin
                            kind_next = KIND_ERR;
                        end
                        else
                        begin
                            if ({1'b0, fbn} < 33'(DIRECT_REFS))
                            begin
                                kind_next = KIND_DIRECT;
                                slot_sel  = fbn;
                            end
                            else if ({1'b0, fbn} < 33'(IND_END))
                            begin
                                kind_next = KIND_INDIRECT;
                                slot_sel  = 32'(DIRECT_REFS) + (ind_off >> RPB_W);
                                p3_next   = ind_off[RPB_W-1:0];
                            end
                            else
                            begin
                                kind_next = KIND_DOUBLE;
                                slot_sel  = 32'(DIRECT_REFS + INDIRECT_REFS)
                                            + (dbl_off >> (2 * RPB_W));
                                p2_next   = dbl_off[2*RPB_W-1:RPB_W];
                                p3_next   = dbl_off[RPB_W-1:0];
                            end
                            inode_re    = 1'b1;
                            inode_raddr = inode_addr(req.inode, SLOT_W'(slot_sel));
                        end
                    end
                    else
                    begin
                        if (req.cmd == CMD_LOAD_INODE)
                        begin
                            inode_we = ino_ok && 32'(req.slot) < 32'(SLOTS_PER_INODE);
                        end
                        else if (req.cmd == CMD_LOAD_WORD)
                        begin
                            word_we = 32'(req.data_block) < 32'(DATA_BLOCKS)
                                      && 32'(req.word_index) < 32'(REFS_PER_BLOCK);
                        end
                        out_valid_next  = 1'b1;
                        out_ref_next    = 32'd0;
                        out_status_next = STAT_OK;
                    end
                end
            end

            ST_INODE, ST_MID:
            begin
                if (state_reg == ST_INODE && kind_reg == KIND_ERR)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_ref_next    = 32'd0;
                        out_status_next = STAT_RANGE;
                        state_next      = ST_IDLE;
                    end
                end
                else if (state_reg == ST_INODE && kind_reg == KIND_DIRECT)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_ref_next    = inode_rdata;
                        out_status_next = STAT_OK;
                        state_next      = ST_IDLE;
                    end
                end
                else if (ref_null || ref_beyond)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_ref_next    = ref_null ? null_ref_reg : 32'd0;
                        out_status_next = ref_null ? STAT_OK : STAT_BEYOND;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    // Follow the reference into the block store.
                    word_re = 1'b1;
                    if (state_reg == ST_INODE && kind_reg == KIND_DOUBLE)
                    begin
                        word_raddr = word_addr(cur_ref, p2_reg);
                        state_next = ST_MID;
                    end
                    else
                    begin
                        word_raddr = word_addr(cur_ref, p3_reg);
                        state_next = ST_FINAL;
                    end
                end
            end

            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_ref_next    = word_rdata;
                    out_status_next = STAT_OK;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kind_reg       <= KIND_ERR;
            out_valid_reg  <= 1'b0;
            null_ref_reg   <= 32'hFFFF_FFFF;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            out_valid_reg  <= out_valid_next;
            null_ref_reg   <= null_ref_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_reg         <= p2_next;
        p3_reg         <= p3_next;
        out_ref_reg    <= out_ref_next;
        out_status_reg <= out_status_next;
    end

endmodule

[bench/inode_block_map_lookup_checker.sv]
`timescale 1ns / 1ps

// Watches the request, result and configuration channels, keeps a private copy of both
// reference stores and the null value, and checks every result beat in order.
module inode_block_map_lookup_checker
    import ibml_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    ibml_req_if   req,
    ibml_rsp_if   rsp,
    ibml_cfg_if   cfg,
    output int    failures,
    output int    outstanding
);

    typedef struct packed {
        logic [31:0] block_ref;
        status_t     status;
    } map_result_t;

    logic [31:0] inode_tbl [INODE_STORE_DEPTH];
    logic [31:0] word_tbl [WORD_STORE_DEPTH];
    logic [31:0] null_ref;
    map_result_t expected_refs [$];

    // Applies one request beat to the private stores and returns the result it must give.
    function automatic map_result_t resolve_beat(input logic [1:0] cmd, input logic [5:0] ino,
                                                 input logic [2:0] slot, input logic [7:0] blk,
                                                 input logic [7:0] widx, input logic [31:0] val,
                                                 input logic [31:0] fbn);
        map_result_t res;
        longint      pos;
        logic [31:0] r;
        int          base;
        int          hops;
        int          idx [2];
        res.block_ref = '0;
        res.status = STAT_OK;
        base = int'(ino) * SLOTS_PER_INODE;
        pos = longint'({32'd0, fbn});
        hops = 0;
        case (cmd)
            CMD_LOAD_INODE:
                if (slot < SLOTS_PER_INODE)
                    inode_tbl[base + int'(slot)] = val;
            CMD_LOAD_WORD:
                word_tbl[int'(blk) * REFS_PER_BLOCK + int'(widx)] = val;
            CMD_LOOKUP:
            begin
                if (pos >= FBN_LIMIT || ino >= INODE_COUNT)
                begin
                    res.status = STAT_RANGE;
                    return res;
                end
                if (pos < DIRECT_REFS)
                    r = inode_tbl[base + int'(pos)];
                else if (pos < IND_END)
                begin
                    pos -= DIRECT_REFS;
                    hops = 1;
                    idx[0] = int'(pos % REFS_PER_BLOCK);
                    r = inode_tbl[base + DIRECT_REFS + int'(pos / REFS_PER_BLOCK)];
                end
                else
                begin
                    pos -= IND_END;
                    hops = 2;
                    idx[0] = int'((pos / REFS_PER_BLOCK) % REFS_PER_BLOCK);
                    idx[1] = int'(pos % REFS_PER_BLOCK);
                    r = inode_tbl[base + DIRECT_REFS + INDIRECT_REFS
                                  + int'(pos / (REFS_PER_BLOCK * REFS_PER_BLOCK))];
                end
                // Every reference that is followed may end the walk early.
                for (int h = 0; h < hops; h++)
                begin
                    if (r == null_ref)
                    begin
                        res.block_ref = null_ref;
                        return res;
                    end
                    if (r >= DATA_BLOCKS)
                    begin
                        res.status = STAT_BEYOND;
                        return res;
                    end
                    r = word_tbl[int'(r) * REFS_PER_BLOCK + idx[h]];
                end
                res.block_ref = r;
            end
            default: ;
        endcase
        return res;
    endfunction

    // The result beat is matched before a request beat of the same edge is queued, so a
    // stray result can never pair with the item that was only just taken.
    always @(posedge clk)
    begin
        map_result_t want;
        if (!rst_n)
        begin
            failures = 0;
            outstanding = 0;
            null_ref = 32'hFFFF_FFFF;
            expected_refs.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_refs.size() == 0)
                begin
                    $display("%0t: unexpected result beat: block_ref %h status %0d",
                             $time, rsp.block_ref, rsp.status);
                    failures++;
                end
                else
                begin
                    want = expected_refs.pop_front();
                    if (rsp.block_ref !== want.block_ref)
                    begin
                        $display("%0t: block_ref expected %h, got %h",
                                 $time, want.block_ref, rsp.block_ref);
                        failures++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, rsp.status);
                        failures++;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
                null_ref = cfg.data;
            if (req.valid && req.ready)
                expected_refs.push_back(resolve_beat(req.cmd, req.inode, req.slot,
                                                     req.data_block, req.word_index,
                                                     req.value, req.file_block));
            outstanding = expected_refs.size();
        end
    end

endmodule

[bench/inode_block_map_lookup_test.sv]
`timescale 1ns / 1ps

module inode_block_map_lookup_test;

    import ibml_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PHASE_ITEMS = 175;

    typedef struct {
        logic [1:0]  cmd;
        logic [5:0]  inode;
        logic [2:0]  slot;
        logic [7:0]  data_block;
        logic [7:0]  word_index;
        logic [31:0] value;
        logic [31:0] file_block;
    } req_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    int   failures;
    int   outstanding;
    bit   quiet = 1'b0;
    int   work_items = 0;

    // What has been loaded so far; lookups are only sent along paths that are fully loaded.
    logic [31:0] slot_val [INODE_STORE_DEPTH];
    bit          slot_set [INODE_STORE_DEPTH];
    logic [31:0] word_val [WORD_STORE_DEPTH];
    bit          word_set [WORD_STORE_DEPTH];
    logic [31:0] null_now = 32'hFFFF_FFFF;

    ibml_req_if req();
    ibml_rsp_if rsp();
    ibml_cfg_if cfg();

    inode_block_map_lookup i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    inode_block_map_lookup_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
        rsp.ready = quiet || ($urandom_range(0, 99) >= 19);

    function automatic req_beat_t random_beat();
        req_beat_t b;
        b.cmd = CMD_LOOKUP;
        b.inode = 6'($urandom);
        b.slot = 3'($urandom);
        b.data_block = 8'($urandom);
        b.word_index = 8'($urandom);
        b.value = $urandom;
        b.file_block = $urandom;
        return b;
    endfunction

    // Pointers mostly name a few low blocks so that indirect tables get shared and reused.
    function automatic logic [31:0] ref_value(input bit pointer);
        int pick;
        pick = $urandom_range(0, 99);
        if (pointer)
        begin
            if (pick < 70)
                return $urandom_range(0, 15);
            if (pick < 80)
                return $urandom_range(0, DATA_BLOCKS - 1);
            if (pick < 90)
                return null_now;
            return $urandom_range(DATA_BLOCKS, 32'hFFFF_FFFF);
        end
        if (pick < 15)
            return null_now;
        if (pick < 30)
            return $urandom_range(0, DATA_BLOCKS - 1);
        return $urandom;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat was taken.
    task automatic send_beat(input req_beat_t b);
        int at;
        if (b.cmd == CMD_LOAD_INODE && b.slot < SLOTS_PER_INODE)
        begin
            at = int'(b.inode) * SLOTS_PER_INODE + int'(b.slot);
            slot_val[at] = b.value;
            slot_set[at] = 1'b1;
        end
        if (b.cmd == CMD_LOAD_WORD)
        begin
            at = int'(b.data_block) * REFS_PER_BLOCK + int'(b.word_index);
            word_val[at] = b.value;
            word_set[at] = 1'b1;
        end
        if (b.cmd != CMD_UNUSED && !(b.cmd == CMD_LOAD_INODE && b.slot >= SLOTS_PER_INODE))
            work_items++;
        while (!quiet && $urandom_range(0, 99) < 19)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.cmd = b.cmd;
        req.inode = b.inode;
        req.slot = b.slot;
        req.data_block = b.data_block;
        req.word_index = b.word_index;
        req.value = b.value;
        req.file_block = b.file_block;
        req.valid = 1'b1;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    task automatic load_slot(input logic [5:0] ino, input logic [2:0] slot,
                             input logic [31:0] val);
        req_beat_t b;
        b = random_beat();
        b.cmd = CMD_LOAD_INODE;
        b.inode = ino;
        b.slot = slot;
        b.value = val;
        send_beat(b);
    endtask

    task automatic load_word(input logic [7:0] blk, input logic [7:0] widx,
                             input logic [31:0] val);
        req_beat_t b;
        b = random_beat();
        b.cmd = CMD_LOAD_WORD;
        b.data_block = blk;
        b.word_index = widx;
        b.value = val;
        send_beat(b);
    endtask

    task automatic lookup(input logic [5:0] ino, input logic [31:0] fbn);
        req_beat_t b;
        b = random_beat();
        b.cmd = CMD_LOOKUP;
        b.inode = ino;
        b.file_block = fbn;
        send_beat(b);
    endtask

    task automatic fetch_slot(input logic [5:0] ino, input logic [2:0] slot, input bit pointer,
                              input bit fill, output bit ok, output logic [31:0] val);
        int at;
        at = int'(ino) * SLOTS_PER_INODE + int'(slot);
        ok = 1'b1;
        if (slot_set[at])
            val = slot_val[at];
        else if (fill)
        begin
            val = ref_value(pointer);
            load_slot(ino, slot, val);
        end
        else
            ok = 1'b0;
    endtask

    task automatic fetch_word(input logic [7:0] blk, input int widx, input bit pointer,
                              input bit fill, output bit ok, output logic [31:0] val);
        int at;
        at = int'(blk) * REFS_PER_BLOCK + widx;
        ok = 1'b1;
        if (word_set[at])
            val = word_val[at];
        else if (fill)
        begin
            val = ref_value(pointer);
            load_word(blk, 8'(widx), val);
        end
        else
            ok = 1'b0;
    endtask

    // Follows the path a lookup takes. With fill set, every entry not yet loaded is loaded
    // first with a random reference; otherwise ok tells whether the lookup is safe to send.
    task automatic walk_path(input logic [5:0] ino, input logic [31:0] fbn, input bit fill,
                             output bit ok);
        longint      pos;
        logic [31:0] r;
        int          hops;
        int          idx [2];
        ok = 1'b1;
        pos = longint'({32'd0, fbn});
        if (pos >= FBN_LIMIT)
            return;
        if (pos < DIRECT_REFS)
        begin
            fetch_slot(ino, 3'(pos), 1'b0, fill, ok, r);
            return;
        end
        if (pos < IND_END)
        begin
            pos -= DIRECT_REFS;
            hops = 1;
            idx[0] = int'(pos % REFS_PER_BLOCK);
            fetch_slot(ino, 3'(DIRECT_REFS + pos / REFS_PER_BLOCK), 1'b1, fill, ok, r);
        end
        else
        begin
            pos -= IND_END;
            hops = 2;
            idx[0] = int'((pos / REFS_PER_BLOCK) % REFS_PER_BLOCK);
            idx[1] = int'(pos % REFS_PER_BLOCK);
            fetch_slot(ino, 3'(DIRECT_REFS + INDIRECT_REFS
                               + pos / (REFS_PER_BLOCK * REFS_PER_BLOCK)),
                       1'b1, fill, ok, r);
        end
        for (int h = 0; h < hops && ok; h++)
        begin
            if (r == null_now || r >= DATA_BLOCKS)
                return;
            fetch_word(r[7:0], idx[h], h < hops - 1, fill, ok, r);
        end
    endtask

    task automatic random_step();
        req_beat_t   b;
        bit          ok;
        int          pick;
        logic [31:0] fbn;
        b = random_beat();
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0, 1, 2: fbn = $urandom_range(0, DIRECT_REFS - 1);
            3, 4, 5: fbn = $urandom_range(DIRECT_REFS, 32'(IND_END) - 1);
            default: fbn = $urandom_range(32'(IND_END), 32'(FBN_LIMIT) - 1);
        endcase
        if (pick < 60)
        begin
            walk_path(b.inode, fbn, 1'b1, ok);
            lookup(b.inode, fbn);
        end
        else if (pick < 75)
        begin
            walk_path(b.inode, fbn, 1'b0, ok);
            if (ok)
                lookup(b.inode, fbn);
        end
        else if (pick < 85)
            lookup(b.inode, $urandom_range(32'(FBN_LIMIT), 32'hFFFF_FFFF));
        else if (pick < 95)
        begin
            // Stray loads overwrite entries at random, the slot past the last one included.
            b.cmd = $urandom_range(0, 1) ? CMD_LOAD_WORD : CMD_LOAD_INODE;
            send_beat(b);
        end
        else
        begin
            b.cmd = CMD_UNUSED;
            send_beat(b);
        end
    endtask

    task automatic write_null(input logic [31:0] v);
        req.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg.data = v;
        cfg.valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 1'b0;
        null_now = v;
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("inode_block_map_lookup_test failed");
        $finish;
    end

    initial
    begin
        logic [31:0] null_next;
        int          target;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.cmd = CMD_LOAD_INODE;
        req.inode = '0;
        req.slot = '0;
        req.data_block = '0;
        req.word_index = '0;
        req.value = '0;
        req.file_block = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under the reset null value.
        load_slot(6'd0, 3'd0, 32'hFFFF_FFFF);
        load_slot(6'd0, 3'd3, 32'h0000_0000);
        lookup(6'd0, 32'd0);
        lookup(6'd0, 32'd3);
        load_slot(6'd63, 3'd4, 32'd7);
        load_slot(6'd63, 3'd5, 32'hFFFF_FFFF);
        load_slot(6'd63, 3'd6, 32'd9);
        load_word(8'd7, 8'd255, 32'h1234_5678);
        lookup(6'd63, 32'(DIRECT_REFS + 255));
        lookup(6'd63, 32'(DIRECT_REFS + REFS_PER_BLOCK));
        load_word(8'd9, 8'd0, 32'd255);
        load_word(8'd255, 8'd255, 32'hDEAD_BEEF);
        load_word(8'd9, 8'd1, 32'hFFFF_FFFF);
        load_word(8'd9, 8'd2, 32'(DATA_BLOCKS));
        lookup(6'd63, 32'(IND_END) + 32'd255);
        lookup(6'd63, 32'(IND_END) + 32'(REFS_PER_BLOCK));
        lookup(6'd63, 32'(IND_END) + 32'(2 * REFS_PER_BLOCK));
        // References past the data store at the first level of both kinds.
        load_slot(6'd62, 3'd4, 32'(DATA_BLOCKS));
        load_slot(6'd62, 3'd6, 32'hFFFF_FFFE);
        lookup(6'd62, 32'(DIRECT_REFS));
        lookup(6'd62, 32'(IND_END));
        lookup(6'd0, 32'(FBN_LIMIT));
        lookup(6'd0, 32'hFFFF_FFFF);
        load_slot(6'd5, 3'd7, 32'hFFFF_FFFF);
        begin
            req_beat_t b;
            b = random_beat();
            b.cmd = CMD_UNUSED;
            send_beat(b);
        end

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: null_next = 32'h0000_0000;
                1: null_next = $urandom_range(DATA_BLOCKS, 32'hFFFF_FFFE);
                2: null_next = $urandom_range(0, DATA_BLOCKS - 1);
                default: null_next = 32'hFFFF_FFFF;
            endcase
            write_null(null_next);
            quiet = (p == 1);
            target = work_items + PHASE_ITEMS;
            while (work_items < target)
                random_step();
        end
        quiet = 1'b0;

        req.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (failures == 0)
            $display("inode_block_map_lookup_test passed");
        else
            $display("inode_block_map_lookup_test failed");
        $finish;
    end

endmodule
